### sv/gdfo_pkg.sv
// ----------------------------------------------------------------------------
// gdfo_pkg
// Item types, microcode step codes and the control store of the
// depth-first order core.
// ----------------------------------------------------------------------------
package gdfo_pkg;

	localparam int NUM_VTX = 64;
	localparam int VW = $clog2(NUM_VTX + 1);
	localparam int SW = 5;

	typedef struct packed {
		logic [1:0]    cmd;
		logic [VW-1:0] vertex_a;
		logic [VW-1:0] vertex_b;
	} gdfo_item_t;

	typedef struct packed {
		logic [VW-1:0] visited_vertex;
		logic          last;
	} gdfo_result_t;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_RUN   = 2'd2;

	// datapath actions
	localparam logic [3:0] A_NONE  = 4'd0;
	localparam logic [3:0] A_CLEAR = 4'd1;
	localparam logic [3:0] A_RD_A  = 4'd2;
	localparam logic [3:0] A_WR_A  = 4'd3;
	localparam logic [3:0] A_RD_B  = 4'd4;
	localparam logic [3:0] A_WR_B  = 4'd5;
	localparam logic [3:0] A_INIT  = 4'd6;
	localparam logic [3:0] A_EMIT  = 4'd7;
	localparam logic [3:0] A_NEXT  = 4'd8;
	localparam logic [3:0] A_POP   = 4'd9;
	localparam logic [3:0] A_TOP   = 4'd10;
	localparam logic [3:0] A_SWEEP = 4'd11;

	// jump conditions
	localparam logic [3:0] C_NEVER   = 4'd0;
	localparam logic [3:0] C_ALWAYS  = 4'd1;
	localparam logic [3:0] C_NSTART  = 4'd2;
	localparam logic [3:0] C_ADD     = 4'd3;
	localparam logic [3:0] C_RUN     = 4'd4;
	localparam logic [3:0] C_NCLR    = 4'd5;
	localparam logic [3:0] C_BAD_ADD = 4'd6;
	localparam logic [3:0] C_BAD_RUN = 4'd7;
	localparam logic [3:0] C_LAST    = 4'd8;
	localparam logic [3:0] C_FOUND   = 4'd9;
	localparam logic [3:0] C_DEPTH1  = 4'd10;

	// step codes
	localparam logic [SW-1:0] S_IDLE   = 5'd0;
	localparam logic [SW-1:0] S_DEC    = 5'd1;
	localparam logic [SW-1:0] S_DEC2   = 5'd2;
	localparam logic [SW-1:0] S_DEC3   = 5'd3;
	localparam logic [SW-1:0] S_CLR    = 5'd4;
	localparam logic [SW-1:0] S_ADD    = 5'd5;
	localparam logic [SW-1:0] S_RD_A   = 5'd6;
	localparam logic [SW-1:0] S_WR_A   = 5'd7;
	localparam logic [SW-1:0] S_RD_B   = 5'd8;
	localparam logic [SW-1:0] S_WR_B   = 5'd9;
	localparam logic [SW-1:0] S_RUN    = 5'd10;
	localparam logic [SW-1:0] S_INIT   = 5'd11;
	localparam logic [SW-1:0] S_EMIT   = 5'd12;
	localparam logic [SW-1:0] S_FIND   = 5'd13;
	localparam logic [SW-1:0] S_POP    = 5'd14;
	localparam logic [SW-1:0] S_TOP    = 5'd15;
	localparam logic [SW-1:0] S_SWEEP  = 5'd16;

	typedef struct packed {
		logic [3:0]    act;
		logic [3:0]    cond;
		logic [SW-1:0] target;
	} gdfo_uword_t;

	function automatic gdfo_uword_t gdfo_rom(input logic [SW-1:0] step);
		gdfo_uword_t w;
		case (step)
			S_IDLE:  w = '{A_NONE,  C_NSTART,  S_IDLE};
			S_DEC:   w = '{A_NONE,  C_ADD,     S_ADD};
			S_DEC2:  w = '{A_NONE,  C_RUN,     S_RUN};
			S_DEC3:  w = '{A_NONE,  C_NCLR,    S_IDLE};
			S_CLR:   w = '{A_CLEAR, C_ALWAYS,  S_IDLE};
			S_ADD:   w = '{A_NONE,  C_BAD_ADD, S_IDLE};
			S_RD_A:  w = '{A_RD_A,  C_NEVER,   S_IDLE};
			S_WR_A:  w = '{A_WR_A,  C_NEVER,   S_IDLE};
			S_RD_B:  w = '{A_RD_B,  C_NEVER,   S_IDLE};
			S_WR_B:  w = '{A_WR_B,  C_ALWAYS,  S_IDLE};
			S_RUN:   w = '{A_NONE,  C_BAD_RUN, S_IDLE};
			S_INIT:  w = '{A_INIT,  C_NEVER,   S_IDLE};
			S_EMIT:  w = '{A_EMIT,  C_LAST,    S_IDLE};
			S_FIND:  w = '{A_NEXT,  C_FOUND,   S_EMIT};
			S_POP:   w = '{A_POP,   C_DEPTH1,  S_SWEEP};
			S_TOP:   w = '{A_TOP,   C_ALWAYS,  S_FIND};
			S_SWEEP: w = '{A_SWEEP, C_ALWAYS,  S_EMIT};
			default: w = '{A_NONE,  C_ALWAYS,  S_IDLE};
		endcase
		return w;
	endfunction

endpackage

### sv/graph_depth_first_order_core.sv
// ----------------------------------------------------------------------------
// graph_depth_first_order_core
// Undirected graph store (adjacency bit matrix) with depth-first visit order.
//
// An item is taken when start is high and busy is low. A traversal emits
// every vertex 1..vertex_count once, one per result_strobe pulse, with last
// set on the final one; each vertex costs an emit and a find step and each
// backtrack step a pop, a top and a find step, bound by the single registered
// read port of the adjacency row memory and of the vertex stack. Results
// cannot be held off: take each on its strobe.
// ----------------------------------------------------------------------------
module graph_depth_first_order_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  gdfo_pkg::gdfo_item_t    item,
	output logic                    result_strobe,
	output gdfo_pkg::gdfo_result_t  result,
	input  logic                    cfg_we,
	input  logic [gdfo_pkg::VW-1:0] cfg_wdata
);
	import gdfo_pkg::*;

	localparam int IW = (NUM_VTX > 1) ? $clog2(NUM_VTX) : 1;
	localparam int DW = $clog2(NUM_VTX + 1);

	logic [SW-1:0]           step_q;
	logic [VW-1:0]           vcount_q;
	gdfo_item_t              req_q;
	logic [VW-1:0]           cur_q;
	logic [VW-1:0]           cnt_q;
	logic [DW-1:0]           depth_q;
	logic [NUM_VTX-1:0]      visited_q;
	logic [NUM_VTX-1:0]      row_vld_q;
	logic                    row_vld_s1;
	logic [NUM_VTX-1:0]      adj_rdata_s1;
	logic [VW-1:0]           stk_rdata_s1;
	logic [NUM_VTX-1:0]      adj_mem [NUM_VTX];
	logic [VW-1:0]           stk_mem [NUM_VTX];

	gdfo_uword_t             uw;
	logic [VW-1:0]           n_eff;
	logic [NUM_VTX-1:0]      range_mask;
	logic [NUM_VTX-1:0]      row_eff;
	logic [NUM_VTX-1:0]      cand;
	logic [NUM_VTX-1:0]      wbit;
	logic [IW-1:0]           found_idx;
	logic                    found;
	logic [VW-1:0]           found_vertex;
	logic [IW-1:0]           idx_a, idx_b, idx_cur, adj_raddr, adj_waddr;
	logic                    adj_re, adj_we;
	logic                    bad_a, bad_b;
	logic                    last_c;
	logic                    jump;

	assign uw   = gdfo_rom(step_q);
	assign busy = (step_q != S_IDLE);

	assign n_eff = (int'(vcount_q) > NUM_VTX) ? VW'(NUM_VTX) : vcount_q;

	assign idx_a   = IW'(req_q.vertex_a - VW'(1));
	assign idx_b   = IW'(req_q.vertex_b - VW'(1));
	assign idx_cur = IW'(cur_q - VW'(1));

	assign bad_a  = (req_q.vertex_a == '0) || (req_q.vertex_a > n_eff);
	assign bad_b  = (req_q.vertex_b == '0) || (req_q.vertex_b > n_eff);
	assign last_c = ((cnt_q + VW'(1)) == n_eff);

	always_comb begin
		for (int i = 0; i < NUM_VTX; i++) begin
			range_mask[i] = (i < int'(n_eff));
		end
	end

	assign row_eff = row_vld_s1 ? adj_rdata_s1 : '0;
	assign cand    = (uw.act == A_SWEEP) ? (~visited_q & range_mask)
	                                     : (row_eff & ~visited_q & range_mask);

	always_comb begin
		found_idx = '0;
		for (int i = NUM_VTX - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found_idx = IW'(i);
			end
		end
	end
	assign found        = |cand;
	assign found_vertex = VW'(found_idx) + VW'(1);

	always_comb begin
		case (uw.cond)
			C_NEVER:   jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_NSTART:  jump = !start;
			C_ADD:     jump = (req_q.cmd == CMD_ADD);
			C_RUN:     jump = (req_q.cmd == CMD_RUN);
			C_NCLR:    jump = (req_q.cmd != CMD_CLEAR);
			C_BAD_ADD: jump = bad_a || bad_b || (req_q.vertex_a == req_q.vertex_b);
			C_BAD_RUN: jump = bad_a;
			C_LAST:    jump = last_c;
			C_FOUND:   jump = found;
			C_DEPTH1:  jump = (depth_q == DW'(1));
			default:   jump = 1'b1;
		endcase
	end

	// adjacency port control
	always_comb begin
		adj_re    = 1'b0;
		adj_raddr = idx_a;
		case (uw.act)
			A_RD_A: begin
				adj_re    = 1'b1;
				adj_raddr = idx_a;
			end
			A_RD_B: begin
				adj_re    = 1'b1;
				adj_raddr = idx_b;
			end
			A_EMIT: begin
				adj_re    = 1'b1;
				adj_raddr = idx_cur;
			end
			A_TOP: begin
				adj_re    = 1'b1;
				adj_raddr = IW'(stk_rdata_s1 - VW'(1));
			end
			default: begin
				adj_re = 1'b0;
			end
		endcase
	end

	assign adj_we    = (uw.act == A_WR_A) || (uw.act == A_WR_B);
	assign adj_waddr = (uw.act == A_WR_A) ? idx_a : idx_b;

	always_comb begin
		wbit = '0;
		wbit[(uw.act == A_WR_A) ? idx_b : idx_a] = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= row_eff | wbit;
		end
		if (adj_re) begin
			adj_rdata_s1 <= adj_mem[adj_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (uw.act == A_EMIT) begin
			stk_mem[depth_q[IW-1:0]] <= cur_q;
		end
		if (uw.act == A_POP) begin
			stk_rdata_s1 <= stk_mem[IW'(depth_q - DW'(2))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= S_IDLE;
			vcount_q      <= VW'(NUM_VTX);
			visited_q     <= '0;
			row_vld_q     <= '0;
			row_vld_s1    <= 1'b0;
			depth_q       <= '0;
			cnt_q         <= '0;
			result_strobe <= 1'b0;
		end else begin
			step_q        <= jump ? uw.target : step_q + SW'(1);
			result_strobe <= (uw.act == A_EMIT);
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (adj_re) begin
				row_vld_s1 <= row_vld_q[adj_raddr];
			end
			case (uw.act)
				A_CLEAR: begin
					row_vld_q <= '0;
					visited_q <= '0;
				end
				A_WR_A, A_WR_B: begin
					row_vld_q[adj_waddr] <= 1'b1;
				end
				A_INIT: begin
					visited_q <= '0;
					depth_q   <= '0;
					cnt_q     <= '0;
				end
				A_EMIT: begin
					visited_q[idx_cur] <= 1'b1;
					depth_q            <= depth_q + DW'(1);
					cnt_q              <= cnt_q + VW'(1);
				end
				A_POP: begin
					depth_q <= depth_q - DW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == S_IDLE && start) begin
			req_q <= item;
		end
		case (uw.act)
			A_INIT:  cur_q <= req_q.vertex_a;
			A_NEXT:  cur_q <= found_vertex;
			A_SWEEP: cur_q <= found_vertex;
			default: cur_q <= cur_q;
		endcase
		if (uw.act == A_EMIT) begin
			result.visited_vertex <= cur_q;
			result.last           <= last_c;
		end
	end

	a_emit_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == S_EMIT |-> !visited_q[idx_cur])
		else $error("emitting a vertex already visited");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == S_EMIT && last_c) |=> (step_q == S_IDLE && result_strobe && result.last))
		else $error("traversal did not end on the last vertex");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(depth_q) <= NUM_VTX)
		else $error("stack depth overflow");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> step_q == S_DEC)
		else $error("accepted item not decoded");

endmodule
